/* hdl/ifhg_pkg.sv */
// Shared types and constants for the IPv4 fragment header generator.
`default_nettype none

package ifhg_pkg;

  // Fixed header length of every fragment and the smallest MTU that can fragment
  localparam logic [15:0] HdrBytes   = 16'd20;
  localparam logic [15:0] MinMtu     = 16'd28;
  localparam logic [6:0]  MaxFragCap = 7'd64;
  localparam logic [15:0] PayMask    = 16'hFFF8;

  // Bit positions in the flags/offset word
  localparam int unsigned FlagDfBit = 14;
  localparam int unsigned FlagMfBit = 13;

  // Result status codes
  localparam logic [1:0] StatusOk      = 2'd0;
  localparam logic [1:0] StatusInvalid = 2'd1;
  localparam logic [1:0] StatusTooMany = 2'd2;

  // Configuration register indexes
  localparam logic RegMtu     = 1'b0;
  localparam logic RegMaxFrag = 1'b1;

  typedef logic [9:0][15:0] hdr_words_t;

  typedef enum logic [1:0] {
    KIND_ERROR,
    KIND_PASS,
    KIND_FRAG
  } cmd_kind_e;

  // Work handed from the front end to the back end
  typedef struct packed {
    cmd_kind_e   kind;
    logic [1:0]  status;
    logic [15:0] total;
    logic [15:0] flags;
    logic [15:0] csum;
    logic [5:0]  ihl;
    logic [15:0] plen;
    logic [15:0] max_pay;
    logic [18:0] base_sum;
  } cmd_t;

  // One result transaction
  typedef struct packed {
    logic [15:0] frag_len;
    logic [15:0] flags_offset;
    logic [15:0] checksum;
    logic [15:0] payload_start;
    logic [15:0] payload_bytes;
    logic [1:0]  status;
    logic        last;
  } result_t;

endpackage

`default_nettype wire

/* hdl/ipv4_fragment_header_gen.sv */
// IPv4 fragment header generator: configuration registers and block top level.
//
// Usage: one input transaction carries the ten 16-bit header words and the
// captured length; it is taken when push is high and full is low. Results come
// out of a queue: while empty is low the oldest result sits on the frag_*,
// payload_*, status_o and last_fragment_o ports and is taken with pop.
// Each packet, save the case below, yields one or more results, the final one
// flagged by last_fragment_o; errors give a single status result. A fragmenting
// packet with an empty payload gives none.
// A header passes the front end's capture register, the command queue, the
// back end's command register and the result queue. The back end loads a
// command, then emits one result per cycle while the result queue is not
// full; a command queue lets the validating front end take the next header.
// If the receiver stops popping, the result queue fills, the back end holds,
// then the command queue and finally full rises; nothing is dropped.
// Reset clears all queues and sets mtu to 1500 and max_fragments to 64.
// Registers (APB, 32-bit): 0x0 mtu, 0x4 max_fragments. Write only while idle.
`default_nettype none

module ipv4_fragment_header_gen #(
  parameter int unsigned CMD_DEPTH = 2,
  parameter int unsigned RES_DEPTH = 2
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // header channel
  input  wire logic        push,
  output logic             full,
  input  wire logic [15:0] header_word_0_i,
  input  wire logic [15:0] header_word_1_i,
  input  wire logic [15:0] header_word_2_i,
  input  wire logic [15:0] header_word_3_i,
  input  wire logic [15:0] header_word_4_i,
  input  wire logic [15:0] header_word_5_i,
  input  wire logic [15:0] header_word_6_i,
  input  wire logic [15:0] header_word_7_i,
  input  wire logic [15:0] header_word_8_i,
  input  wire logic [15:0] header_word_9_i,
  input  wire logic [15:0] captured_length_i,
  // result channel
  output logic             empty,
  input  wire logic        pop,
  output logic [15:0]      frag_total_len_o,
  output logic [15:0]      frag_flags_offset_o,
  output logic [15:0]      frag_checksum_o,
  output logic [15:0]      payload_start_o,
  output logic [15:0]      payload_bytes_o,
  output logic [1:0]       status_o,
  output logic             last_fragment_o,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [15:0]          mtu_q;
  logic [6:0]           max_frag_q;
  logic                 cfg_wr;
  logic                 reg_idx;

  ifhg_pkg::hdr_words_t hdr;
  ifhg_pkg::cmd_t       fe_cmd, be_cmd;
  ifhg_pkg::result_t    be_res, out_res;
  logic                 fe_cmd_push, cmd_full, cmd_empty, cmd_pop;
  logic                 res_push, res_full;

  // Register access
  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    case (reg_idx)
      ifhg_pkg::RegMtu:     prdata = {16'd0, mtu_q};
      ifhg_pkg::RegMaxFrag: prdata = {25'd0, max_frag_q};
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mtu_q      <= 16'd1500;
      max_frag_q <= 7'd64;
    end else if (cfg_wr) begin
      case (reg_idx)
        ifhg_pkg::RegMtu:     mtu_q      <= pwdata[15:0];
        ifhg_pkg::RegMaxFrag: max_frag_q <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  assign hdr = {header_word_9_i, header_word_8_i, header_word_7_i, header_word_6_i,
                header_word_5_i, header_word_4_i, header_word_3_i, header_word_2_i,
                header_word_1_i, header_word_0_i};

  // Validation and classification
  ifhg_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .full_o     (full),
    .hdr_i      (hdr),
    .cap_i      (captured_length_i),
    .mtu_i      (mtu_q),
    .max_frag_i (max_frag_q),
    .cmd_push_o (fe_cmd_push),
    .cmd_o      (fe_cmd),
    .cmd_full_i (cmd_full)
  );

  // Command queue between the two ends
  ifhg_fifo #(
    .DEPTH (CMD_DEPTH),
    .T     (ifhg_pkg::cmd_t)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fe_cmd_push),
    .data_i  (fe_cmd),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .data_o  (be_cmd),
    .empty_o (cmd_empty)
  );

  // Fragment sequencer
  ifhg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (be_cmd),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (be_res)
  );

  // Result queue
  ifhg_fifo #(
    .DEPTH (RES_DEPTH),
    .T     (ifhg_pkg::result_t)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (be_res),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (out_res),
    .empty_o (empty)
  );

  assign frag_total_len_o    = out_res.frag_len;
  assign frag_flags_offset_o = out_res.flags_offset;
  assign frag_checksum_o     = out_res.checksum;
  assign payload_start_o     = out_res.payload_start;
  assign payload_bytes_o     = out_res.payload_bytes;
  assign status_o            = out_res.status;
  assign last_fragment_o     = out_res.last;

endmodule

`default_nettype wire

/* hdl/ifhg_fifo.sv */
// Small register-based FIFO used for the command and result queues.
`default_nettype none

module ifhg_fifo #(
  parameter int unsigned DEPTH = 2,
  parameter type         T     = logic
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire T     data_i,
  output logic      full_o,
  input  wire logic pop_i,
  output T          data_o,
  output logic      empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  T                mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Pointer and occupancy update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

/* hdl/ifhg_front.sv */
// Front end: captures a header transaction, validates it and builds a command.
`default_nettype none

module ifhg_front (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  output logic                     full_o,
  input  wire ifhg_pkg::hdr_words_t hdr_i,
  input  wire logic [15:0]         cap_i,
  input  wire logic [15:0]         mtu_i,
  input  wire logic [6:0]          max_frag_i,
  output logic                     cmd_push_o,
  output ifhg_pkg::cmd_t           cmd_o,
  input  wire logic                cmd_full_i
);

  ifhg_pkg::hdr_words_t hdr_q;
  logic [15:0]          cap_q;
  logic                 valid_q, valid_d;

  logic                 accept, advance, drop;
  logic [5:0]           ihl;
  logic [15:0]          total, plen, max_pay;
  logic [6:0]           limit;
  logic [22:0]          frag_room;
  ifhg_pkg::cmd_t       cmd;

  // Derived header quantities
  assign ihl       = {hdr_q[0][11:8], 2'b00};
  assign total     = hdr_q[1];
  assign plen      = total - {10'd0, ihl};
  assign max_pay   = (mtu_i - ifhg_pkg::HdrBytes) & ifhg_pkg::PayMask;
  assign limit     = (max_frag_i > ifhg_pkg::MaxFragCap) ? ifhg_pkg::MaxFragCap : max_frag_i;
  assign frag_room = 23'(limit) * 23'(max_pay);

  // Classification in priority order
  always_comb begin
    cmd          = '0;
    cmd.total    = total;
    cmd.flags    = hdr_q[3];
    cmd.csum     = hdr_q[5];
    cmd.ihl      = ihl;
    cmd.plen     = plen;
    cmd.max_pay  = max_pay;
    cmd.base_sum = 19'(hdr_q[0]) + 19'(hdr_q[2]) + 19'(hdr_q[4]) + 19'(hdr_q[6])
                 + 19'(hdr_q[7]) + 19'(hdr_q[8]) + 19'(hdr_q[9]);
    cmd.kind     = ifhg_pkg::KIND_ERROR;
    cmd.status   = ifhg_pkg::StatusInvalid;
    drop         = 1'b0;
    if (cap_q < ifhg_pkg::HdrBytes || max_frag_i == '0) begin
      cmd.kind = ifhg_pkg::KIND_ERROR;
    end else if ({10'd0, ihl} < ifhg_pkg::HdrBytes) begin
      cmd.kind = ifhg_pkg::KIND_ERROR;
    end else if (total > cap_q || total < {10'd0, ihl}) begin
      cmd.kind = ifhg_pkg::KIND_ERROR;
    end else if (total <= mtu_i) begin
      cmd.kind   = ifhg_pkg::KIND_PASS;
      cmd.status = ifhg_pkg::StatusOk;
    end else if (hdr_q[3][ifhg_pkg::FlagDfBit]) begin
      cmd.kind = ifhg_pkg::KIND_ERROR;
    end else if (mtu_i < ifhg_pkg::MinMtu) begin
      cmd.kind = ifhg_pkg::KIND_ERROR;
    end else if (23'(plen) > frag_room) begin
      cmd.kind   = ifhg_pkg::KIND_ERROR;
      cmd.status = ifhg_pkg::StatusTooMany;
    end else begin
      cmd.kind   = ifhg_pkg::KIND_FRAG;
      cmd.status = ifhg_pkg::StatusOk;
      // nothing to send for an empty payload
      drop       = (plen == '0);
    end
  end

  // Handshake between capture stage and command queue
  assign advance    = valid_q && (drop || !cmd_full_i);
  assign cmd_push_o = valid_q && !drop;
  assign cmd_o      = cmd;
  assign full_o     = valid_q && !advance;
  assign accept     = push_i && !full_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (advance) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Captured header, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      hdr_q <= hdr_i;
      cap_q <= cap_i;
    end
  end

endmodule

`default_nettype wire

/* hdl/ifhg_back.sv */
// Back end: turns commands into results, one fragment per cycle while res_full_i is low.
`default_nettype none

module ifhg_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cmd_empty_i,
  input  wire ifhg_pkg::cmd_t cmd_i,
  output logic                cmd_pop_o,
  input  wire logic           res_full_i,
  output logic                res_push_o,
  output ifhg_pkg::result_t   res_o
);

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_e;

  state_e         state_q;
  ifhg_pkg::cmd_t cmd_q;
  logic [15:0]    off_q;

  logic [15:0]    remain, chunk, tl, fo;
  logic [12:0]    fo_off;
  logic           last, mf;
  logic [19:0]    sum;
  logic [16:0]    fold1;
  logic [15:0]    fold2;

  // Current fragment
  assign remain = cmd_q.plen - off_q;
  assign last   = (remain <= cmd_q.max_pay);
  assign chunk  = last ? remain : cmd_q.max_pay;
  assign tl     = ifhg_pkg::HdrBytes + chunk;
  assign fo_off = cmd_q.flags[12:0] + off_q[15:3];
  assign mf     = !last || cmd_q.flags[ifhg_pkg::FlagMfBit];
  assign fo     = {2'b00, mf, fo_off};

  // Ones' complement header checksum, checksum word taken as zero
  assign sum   = 20'(cmd_q.base_sum) + 20'(tl) + 20'(fo);
  assign fold1 = 17'(sum[15:0]) + 17'(sum[19:16]);
  assign fold2 = fold1[15:0] + 16'(fold1[16]);

  always_comb begin
    res_o = '0;
    case (cmd_q.kind)
      ifhg_pkg::KIND_PASS: begin
        res_o.frag_len      = cmd_q.total;
        res_o.flags_offset  = cmd_q.flags;
        res_o.checksum      = cmd_q.csum;
        res_o.payload_start = 16'(cmd_q.ihl);
        res_o.payload_bytes = cmd_q.plen;
        res_o.status        = ifhg_pkg::StatusOk;
        res_o.last          = 1'b1;
      end
      ifhg_pkg::KIND_FRAG: begin
        res_o.frag_len      = tl;
        res_o.flags_offset  = fo;
        res_o.checksum      = ~fold2;
        res_o.payload_start = 16'(cmd_q.ihl) + off_q;
        res_o.payload_bytes = chunk;
        res_o.status        = ifhg_pkg::StatusOk;
        res_o.last          = last;
      end
      default: begin
        res_o.status = cmd_q.status;
        res_o.last   = 1'b1;
      end
    endcase
  end

  assign cmd_pop_o  = (state_q == ST_IDLE) && !cmd_empty_i;
  assign res_push_o = (state_q == ST_EMIT) && !res_full_i;

  // Sequencer: load a command, then emit its results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cmd_q   <= '0;
      off_q   <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (!cmd_empty_i) begin
            cmd_q   <= cmd_i;
            off_q   <= '0;
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (!res_full_i) begin
            if (cmd_q.kind != ifhg_pkg::KIND_FRAG || last) begin
              state_q <= ST_IDLE;
            end else begin
              off_q <= off_q + chunk;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Checks
  a_pop_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |=> (state_q == ST_EMIT) && (off_q == '0))
    else $error("command pop did not start emission");

  a_run_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o && (cmd_q.kind != ifhg_pkg::KIND_FRAG || last) |=> state_q == ST_IDLE)
    else $error("sequencer did not return to idle after final result");

  a_off_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) && (cmd_q.kind == ifhg_pkg::KIND_FRAG) |-> off_q < cmd_q.plen)
    else $error("fragment offset ran past payload");

  a_off_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o && (cmd_q.kind == ifhg_pkg::KIND_FRAG) && !last
    |=> off_q == $past(off_q) + $past(cmd_q.max_pay))
    else $error("non-final fragment not a full payload");

endmodule

`default_nettype wire
